// File: hw/rtl/assert_macros.svh
// Assertion helpers for the RTL files.
// Every property is clocked on the rising edge and is disabled while reset is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ARP_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("%m: assertion failed");
`define ARP_ASSERT_IMPL(label, clk, rst_n, lhs, rhs) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |-> (rhs)) \
        else $error("%m: assertion failed");
`define ARP_ASSERT_NEXT(label, clk, rst_n, lhs, rhs) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |=> (rhs)) \
        else $error("%m: assertion failed");
`else
`define ARP_ASSERT(label, clk, rst_n, prop)
`define ARP_ASSERT_IMPL(label, clk, rst_n, lhs, rhs)
`define ARP_ASSERT_NEXT(label, clk, rst_n, lhs, rhs)
`endif
`endif

// File: hw/rtl/arp_pkg.sv
package arp_pkg;

    // Request codes carried in s_tuser.
    typedef logic [1:0] req_t;
    localparam req_t REQ_LOOKUP = 2'd0;
    localparam req_t REQ_INSERT = 2'd1;
    localparam req_t REQ_SWEEP  = 2'd2;

    // Configuration register indexes.
    typedef logic [1:0] cfg_idx_t;
    localparam cfg_idx_t CFG_LOCAL_IP    = 2'd0;
    localparam cfg_idx_t CFG_SUBNET_MASK = 2'd1;
    localparam cfg_idx_t CFG_LIVE_SEC    = 2'd2;

    localparam int IP_W    = 32;
    localparam int MAC_W   = 48;
    localparam int STAMP_W = 32;
    localparam int LIVE_W  = 16;

    // Slot word in the RAM: ip in the low bits, then mac, then stamp.
    localparam int RAM_W = IP_W + MAC_W + STAMP_W;

    localparam int MS_PER_SECOND = 1000;
    localparam int LIVE_RESET    = 60;

    // Expiry threshold in ms: live_seconds * 1000 + 999, at most 65535999.
    localparam int THRESH_W = 26;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_WRITE,
        ST_DONE
    } state_t;

    // Result of the shared slot compare unit.
    typedef struct packed {
        logic               ip_eq;
        logic               older;
        logic               expired;
        logic [STAMP_W-1:0] age;
    } cmp_res_t;

endpackage

// File: hw/rtl/arp_ram.sv
module arp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8
) (
    input  logic                                      aclk,
    input  logic                                      we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                          wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                          rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// File: hw/rtl/arp_cmp.sv
module arp_cmp (
    input  logic [arp_pkg::IP_W-1:0]     slot_ip,
    input  logic [arp_pkg::STAMP_W-1:0]  slot_stamp,
    input  logic [arp_pkg::IP_W-1:0]     addr,
    input  logic [arp_pkg::STAMP_W-1:0]  now_ms,
    input  logic [arp_pkg::THRESH_W-1:0] thresh,
    input  logic [arp_pkg::STAMP_W-1:0]  best_age,
    output arp_pkg::cmp_res_t            res
);

    logic [arp_pkg::STAMP_W-1:0] age;

    // Age wraps modulo 2^32, as the millisecond clock does.
    assign age = now_ms - slot_stamp;

    always_comb begin
        res.ip_eq   = (slot_ip == addr);
        res.older   = (best_age <= age);
        res.expired = (age > arp_pkg::STAMP_W'(thresh));
        res.age     = age;
    end

endmodule

// File: hw/rtl/arp_cache_table.sv
// ARP cache: maps IPv4 addresses to MAC addresses over ENTRIES slots.
// Input channel s_*: one item per request. s_tuser carries the request kind
// (lookup, insert, age sweep); s_tdata carries addr, new_mac and now_ms.
// Output channel m_*: exactly one result item per request. m_tuser[0] is the
// hit flag and m_tdata holds the resolved MAC, zero when there is no hit.
// Configuration channel cfg_*: index 0 local_ip, 1 subnet_mask, 2 live_seconds.
// It is always ready and is meant to be written while the block is idle.
// From acceptance, a non-broadcast lookup or a sweep walks the slots in SCAN,
// then passes DRAIN and DONE; an insert into a full table does the same with
// WRITE between DRAIN and DONE; an insert into a free slot goes through WRITE
// and DONE; a broadcast lookup or an unused code goes straight to DONE.
// The rate is set by the single read port of the slot RAM, which walks one
// slot per cycle into one shared compare unit; one item is handled at a time.
// The sequencer is back in idle in the same cycle in which the result appears,
// so the next item can be accepted in that cycle.
// s_tready is high only while the sequencer is idle. A finished result sits in
// the output register, so the next item can be accepted while m_tready is low;
// that item then holds in its final state until the output register frees up.
// After reset every slot is invalid, local_ip and subnet_mask are zero and
// live_seconds is 60; the slot RAM itself is not cleared.
`include "assert_macros.svh"

module arp_cache_table #(
    parameter int ENTRIES = 8
) (
    input  logic         aclk,
    input  logic         aresetn,

    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [111:0] s_tdata,   // addr[31:0], new_mac[79:32], now_ms[111:80]
    input  logic [1:0]   s_tuser,   // req_type[1:0]

    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [47:0]  m_tdata,   // found_mac[47:0]
    output logic [0:0]   m_tuser,   // hit[0]

    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [1:0]   cfg_index,
    input  logic [31:0]  cfg_data
);

    localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int IP_W    = arp_pkg::IP_W;
    localparam int MAC_W   = arp_pkg::MAC_W;
    localparam int STAMP_W = arp_pkg::STAMP_W;
    localparam int TH_W    = arp_pkg::THRESH_W;

    // Input payload fields.
    arp_pkg::req_t      s_req;
    logic [IP_W-1:0]    s_addr;
    logic [MAC_W-1:0]   s_mac;
    logic [STAMP_W-1:0] s_now;

    assign s_req  = s_tuser;
    assign s_addr = s_tdata[IP_W-1:0];
    assign s_mac  = s_tdata[IP_W+MAC_W-1:IP_W];
    assign s_now  = s_tdata[IP_W+MAC_W+STAMP_W-1:IP_W+MAC_W];

    // Configuration registers. live_seconds is kept as its expiry threshold
    // in milliseconds, so the sweep compares the raw age without a divider.
    logic [IP_W-1:0] local_ip_reg;
    logic [IP_W-1:0] subnet_mask_reg;
    logic [TH_W-1:0] thresh_reg;
    logic [TH_W-1:0] thresh_cfg;

    assign cfg_ready  = 1'b1;
    assign thresh_cfg = TH_W'(cfg_data[arp_pkg::LIVE_W-1:0]) * TH_W'(arp_pkg::MS_PER_SECOND)
                      + TH_W'(arp_pkg::MS_PER_SECOND - 1);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            local_ip_reg    <= '0;
            subnet_mask_reg <= '0;
            thresh_reg      <= TH_W'(arp_pkg::LIVE_RESET * arp_pkg::MS_PER_SECOND
                                     + arp_pkg::MS_PER_SECOND - 1);
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                arp_pkg::CFG_LOCAL_IP:    local_ip_reg    <= cfg_data;
                arp_pkg::CFG_SUBNET_MASK: subnet_mask_reg <= cfg_data;
                arp_pkg::CFG_LIVE_SEC:    thresh_reg      <= thresh_cfg;
                default: ;
            endcase
        end
    end

    // Sequencer and request registers.
    arp_pkg::state_t    state_reg, state_next;
    arp_pkg::req_t      req_reg, req_next;
    logic [IP_W-1:0]    addr_reg, addr_next;
    logic [MAC_W-1:0]   mac_in_reg, mac_in_next;
    logic [STAMP_W-1:0] now_reg, now_next;
    logic [IDX_W-1:0]   idx_reg, idx_next;
    logic               proc_valid_reg, proc_valid_next;
    logic [IDX_W-1:0]   proc_idx_reg, proc_idx_next;
    logic [IDX_W-1:0]   pick_reg, pick_next;
    logic [STAMP_W-1:0] best_age_reg, best_age_next;
    logic               res_hit_reg, res_hit_next;
    logic [MAC_W-1:0]   res_mac_reg, res_mac_next;
    logic [ENTRIES-1:0] valid_reg, valid_next;

    // Output register.
    logic               m_tvalid_reg, m_tvalid_next;
    logic               m_hit_reg, m_hit_next;
    logic [MAC_W-1:0]   m_mac_reg, m_mac_next;

    // Slot RAM and the shared compare unit.
    logic                     ram_we;
    logic [arp_pkg::RAM_W-1:0] ram_wdata;
    logic [arp_pkg::RAM_W-1:0] ram_rdata;
    logic [IP_W-1:0]          rd_ip;
    logic [MAC_W-1:0]         rd_mac;
    logic [STAMP_W-1:0]       rd_stamp;
    arp_pkg::cmp_res_t        cmp;

    assign ram_wdata = {now_reg, mac_in_reg, addr_reg};
    assign rd_ip     = ram_rdata[IP_W-1:0];
    assign rd_mac    = ram_rdata[IP_W+MAC_W-1:IP_W];
    assign rd_stamp  = ram_rdata[arp_pkg::RAM_W-1:IP_W+MAC_W];

    arp_ram #(
        .WIDTH (arp_pkg::RAM_W),
        .DEPTH (ENTRIES)
    ) u_slot_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (pick_reg),
        .wdata (ram_wdata),
        .raddr (idx_reg),
        .rdata (ram_rdata)
    );

    arp_cmp u_cmp (
        .slot_ip    (rd_ip),
        .slot_stamp (rd_stamp),
        .addr       (addr_reg),
        .now_ms     (now_reg),
        .thresh     (thresh_reg),
        .best_age   (best_age_reg),
        .res        (cmp)
    );

    // Lowest-numbered free slot, used by an insert without scanning the RAM.
    logic             free_any;
    logic [IDX_W-1:0] free_idx;

    assign free_any = ~&valid_reg;

    always_comb begin
        free_idx = '0;
        for (int i = ENTRIES - 1; i >= 0; i--) begin
            if (!valid_reg[i]) begin
                free_idx = IDX_W'(i);
            end
        end
    end

    // The all-ones address and the subnet broadcast both resolve to the
    // all-ones MAC without touching the table.
    logic bcast;
    assign bcast = (s_addr == '1) || (s_addr == (local_ip_reg | ~subnet_mask_reg));

    always_comb begin
        state_next      = state_reg;
        req_next        = req_reg;
        addr_next       = addr_reg;
        mac_in_next     = mac_in_reg;
        now_next        = now_reg;
        idx_next        = idx_reg;
        proc_valid_next = 1'b0;
        proc_idx_next   = proc_idx_reg;
        pick_next       = pick_reg;
        best_age_next   = best_age_reg;
        res_hit_next    = res_hit_reg;
        res_mac_next    = res_mac_reg;
        valid_next      = valid_reg;
        m_tvalid_next   = m_tvalid_reg;
        m_hit_next      = m_hit_reg;
        m_mac_next      = m_mac_reg;
        ram_we          = 1'b0;

        // Evaluate the slot whose RAM word arrived this cycle.
        if (proc_valid_reg) begin
            case (req_reg)
                arp_pkg::REQ_LOOKUP: begin
                    // Only the first matching slot answers.
                    if (valid_reg[proc_idx_reg] && cmp.ip_eq && !res_hit_reg) begin
                        res_hit_next = 1'b1;
                        res_mac_next = rd_mac;
                    end
                end
                arp_pkg::REQ_INSERT: begin
                    // Table is full here; on equal ages the later slot wins.
                    if (cmp.older) begin
                        best_age_next = cmp.age;
                        pick_next     = proc_idx_reg;
                    end
                end
                arp_pkg::REQ_SWEEP: begin
                    if (valid_reg[proc_idx_reg] && cmp.expired) begin
                        valid_next[proc_idx_reg] = 1'b0;
                    end
                end
                default: ;
            endcase
        end

        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        unique case (state_reg)
            arp_pkg::ST_IDLE: begin
                if (s_tvalid) begin
                    req_next      = s_req;
                    addr_next     = s_addr;
                    mac_in_next   = s_mac;
                    now_next      = s_now;
                    idx_next      = '0;
                    pick_next     = '0;
                    best_age_next = '0;
                    res_hit_next  = 1'b0;
                    res_mac_next  = '0;
                    case (s_req)
                        arp_pkg::REQ_LOOKUP: begin
                            if (bcast) begin
                                res_hit_next = 1'b1;
                                res_mac_next = '1;
                                state_next   = arp_pkg::ST_DONE;
                            end else begin
                                state_next = arp_pkg::ST_SCAN;
                            end
                        end
                        arp_pkg::REQ_INSERT: begin
                            if (free_any) begin
                                pick_next  = free_idx;
                                state_next = arp_pkg::ST_WRITE;
                            end else begin
                                state_next = arp_pkg::ST_SCAN;
                            end
                        end
                        arp_pkg::REQ_SWEEP: state_next = arp_pkg::ST_SCAN;
                        default:            state_next = arp_pkg::ST_DONE;
                    endcase
                end
            end
            arp_pkg::ST_SCAN: begin
                // Issue one RAM read per cycle; its word is evaluated next cycle.
                proc_valid_next = 1'b1;
                proc_idx_next   = idx_reg;
                if (idx_reg == IDX_W'(ENTRIES - 1)) begin
                    idx_next   = '0;
                    state_next = arp_pkg::ST_DRAIN;
                end else begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            arp_pkg::ST_DRAIN: begin
                state_next = (req_reg == arp_pkg::REQ_INSERT) ? arp_pkg::ST_WRITE
                                                              : arp_pkg::ST_DONE;
            end
            arp_pkg::ST_WRITE: begin
                ram_we              = 1'b1;
                valid_next[pick_reg] = 1'b1;
                state_next          = arp_pkg::ST_DONE;
            end
            arp_pkg::ST_DONE: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_hit_next    = res_hit_reg;
                    m_mac_next    = res_mac_reg;
                    state_next    = arp_pkg::ST_IDLE;
                end
            end
            default: state_next = arp_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= arp_pkg::ST_IDLE;
            proc_valid_reg <= 1'b0;
            valid_reg      <= '0;
            m_tvalid_reg   <= 1'b0;
        end else begin
            state_reg      <= state_next;
            proc_valid_reg <= proc_valid_next;
            valid_reg      <= valid_next;
            m_tvalid_reg   <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        req_reg      <= req_next;
        addr_reg     <= addr_next;
        mac_in_reg   <= mac_in_next;
        now_reg      <= now_next;
        idx_reg      <= idx_next;
        proc_idx_reg <= proc_idx_next;
        pick_reg     <= pick_next;
        best_age_reg <= best_age_next;
        res_hit_reg  <= res_hit_next;
        res_mac_reg  <= res_mac_next;
        m_hit_reg    <= m_hit_next;
        m_mac_reg    <= m_mac_next;
    end

    assign s_tready   = (state_reg == arp_pkg::ST_IDLE);
    assign m_tvalid   = m_tvalid_reg;
    assign m_tdata    = m_mac_reg;
    assign m_tuser[0] = m_hit_reg;

    // An accepted item always moves the sequencer out of idle.
    `ARP_ASSERT_NEXT(a_accept_leaves_idle, aclk, aresetn, s_tvalid && s_tready,
                     state_reg != arp_pkg::ST_IDLE)
    // A miss never carries a MAC.
    `ARP_ASSERT_IMPL(a_miss_mac_zero, aclk, aresetn, m_tvalid_reg && !m_hit_reg,
                     m_mac_reg == '0)
    // RAM words are evaluated only while the table walk is in flight.
    `ARP_ASSERT_IMPL(a_eval_in_scan, aclk, aresetn, proc_valid_reg,
                     state_reg == arp_pkg::ST_SCAN || state_reg == arp_pkg::ST_DRAIN)
    // Slots are written only on behalf of an insert.
    `ARP_ASSERT_IMPL(a_write_on_insert, aclk, aresetn, state_reg == arp_pkg::ST_WRITE,
                     req_reg == arp_pkg::REQ_INSERT)

endmodule
